>>> rtl/lsf_pkg.sv
// ----------------------------------------------------------------------------
// lsf_pkg
// Shared widths, register indexes and word types of the Laplacian sharpen
// filter.
// ----------------------------------------------------------------------------
package lsf_pkg;

  localparam int MAX_WIDTH_DEF = 2048;
  localparam int CFG_W         = 12;
  localparam int PIX_W         = 8;
  localparam int ROW_W         = 12;
  localparam int COL_W         = 11;
  localparam int TDATA_W       = 32;
  localparam int MIN_DIM       = 3;
  localparam int WIDTH_RESET   = 640;
  localparam int HEIGHT_RESET  = 480;
  localparam int OQ_DEPTH      = 4;

  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  // Neighborhood taps read from the line store.
  typedef struct packed {
    logic [PIX_W-1:0] center;
    logic [PIX_W-1:0] up;
    logic [PIX_W-1:0] right;
  } lsf_taps_t;

  // One result word.
  typedef struct packed {
    logic [PIX_W-1:0] sharpened;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
    logic             frame_done;
  } lsf_result_t;

endpackage

>>> rtl/lsf_line_store.sv
// ----------------------------------------------------------------------------
// lsf_line_store
// Two-row line store: one entry per column holds the pixel one row above and
// two rows above. Synchronous reads at the column and its right neighbor,
// with forwarding of the write-back in the same cycle.
// ----------------------------------------------------------------------------
module lsf_line_store #(
  parameter int DEPTH  = lsf_pkg::MAX_WIDTH_DEF,
  parameter int ADDR_W = $clog2(lsf_pkg::MAX_WIDTH_DEF)
) (
  input  logic                      clk,
  input  logic                      rd_en,
  input  logic [ADDR_W-1:0]         rd_addr,
  input  logic [ADDR_W-1:0]         rd_addr_right,
  input  logic                      wr_en,
  input  logic [ADDR_W-1:0]         wr_addr,
  input  logic [lsf_pkg::PIX_W-1:0] wr_above,
  input  logic [lsf_pkg::PIX_W-1:0] wr_two_above,
  output lsf_pkg::lsf_taps_t        taps
);
  import lsf_pkg::*;

  // Entry layout: {two rows above, one row above}.
  logic [2*PIX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_two_above, wr_above};
    end
  end

  // Forward the write of this edge so a read of the same column sees it.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        taps.up     <= wr_two_above;
        taps.center <= wr_above;
      end else begin
        taps.up     <= mem[rd_addr][2*PIX_W-1:PIX_W];
        taps.center <= mem[rd_addr][PIX_W-1:0];
      end
      if (wr_en && (wr_addr == rd_addr_right)) begin
        taps.right <= wr_above;
      end else begin
        taps.right <= mem[rd_addr_right][PIX_W-1:0];
      end
    end
  end

endmodule

>>> rtl/lsf_out_fifo.sv
// ----------------------------------------------------------------------------
// lsf_out_fifo
// Small result queue: takes one or two words per cycle, gives one word per
// cycle to the output stream while it is ready.
// ----------------------------------------------------------------------------
module lsf_out_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic                 push_two,
  input  lsf_pkg::lsf_result_t in_a,
  input  lsf_pkg::lsf_result_t in_b,
  output logic                 space_two,
  output logic                 out_valid,
  input  logic                 out_ready,
  output lsf_pkg::lsf_result_t out_data
);
  import lsf_pkg::*;

  localparam int PTR_W = $clog2(OQ_DEPTH);
  localparam int CNT_W = $clog2(OQ_DEPTH + 1);

  lsf_result_t      q [OQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [1:0]       n_push;
  logic             pop;

  assign out_valid = (count != '0);
  assign out_data  = q[rd_ptr];
  assign space_two = (count <= CNT_W'(OQ_DEPTH - 2));
  assign pop       = out_valid && out_ready;

  always_comb begin
    n_push     = push ? (push_two ? 2'd2 : 2'd1) : 2'd0;
    count_next = count + CNT_W'(n_push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(n_push);
      rd_ptr <= rd_ptr + PTR_W'(pop);
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= in_a;
      if (push_two) begin
        q[wr_ptr + PTR_W'(1)] <= in_b;
      end
    end
  end

endmodule

>>> rtl/laplacian_sharpen_filter_core.sv
// ----------------------------------------------------------------------------
// laplacian_sharpen_filter_core
// 3x3 cross-kernel Laplacian sharpen over a raster stream of 8-bit grey
// pixels, with a two-row line store and border zeroing.
// ----------------------------------------------------------------------------
// Takes one pixel per clock while the output queue has room. A pixel at
// (row r, column c) yields the result for (r-1, c): 5*center minus up, down,
// left and right, clamped to 0..255, and zero on every border position.
// Pixels of row 0 yield nothing; pixels of the last row yield two words, the
// result above and the bottom-border zero, so the output side then runs at
// one word per clock when not stalled and input is held back. A taken pixel
// goes through the synchronous read of the line store, then the kernel and
// the write-back, after which its result sits in a four-word output queue.
// tuser on the input forces row and column to zero; the counters also wrap
// by themselves at the end of a frame. frame_width is clamped to 3..MAX_WIDTH
// and frame_height to at least 3 at the moment of the write. Write
// configuration only while the block is idle. The line store needs
// no clearing after reset: row 0 writes every entry before a result uses it.
// ----------------------------------------------------------------------------
module laplacian_sharpen_filter_core #(
  parameter int MAX_WIDTH = lsf_pkg::MAX_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // Config write port
  input  logic                        cfg_we,
  input  logic [0:0]                  cfg_index,
  input  logic [lsf_pkg::CFG_W-1:0]   cfg_data,
  // Pixel input stream
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,  // [7:0] pixel
  input  logic                        s_axis_tuser,  // [0] start_of_frame
  // Result output stream
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // [7:0] sharpened, [19:8] out_row, [30:20] out_col, [31] zero
  output logic [lsf_pkg::TDATA_W-1:0] m_axis_tdata,
  output logic                        m_axis_tlast,  // last result of this pixel
  output logic                        m_axis_tuser   // [0] frame_done
);
  import lsf_pkg::*;

  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int WW  = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
  localparam int CW  = WW + 1;
  localparam logic [WW-1:0]    MAX_W   = WW'(MAX_WIDTH);
  localparam logic [WW-1:0]    MIN_W   = WW'(MIN_DIM);
  localparam logic [ROW_W-1:0] MIN_H   = ROW_W'(MIN_DIM);
  localparam logic [AW:0]      COL_END = (AW + 1)'(MAX_WIDTH);

  // Clamped frame size
  logic [WW-1:0]    width_eff;
  logic [ROW_W-1:0] height_eff;
  logic [WW-1:0]    cfg_w_ext;
  logic [WW-1:0]    width_clamp;
  logic [ROW_W-1:0] height_clamp;

  // Position counters
  logic [AW-1:0]    col_q;
  logic [ROW_W-1:0] row_q;

  // Position of the pixel being offered
  logic [AW-1:0]    col_sel;
  logic [ROW_W-1:0] row_sel;
  logic             col_wrap;
  logic [ROW_W:0]   row_adv;
  logic [ROW_W-1:0] cur_row;
  logic [AW-1:0]    cur_col;
  logic [AW:0]      col_inc;
  logic             end_of_row;
  logic [ROW_W:0]   row_inc;
  logic [ROW_W-1:0] next_row;
  logic [AW-1:0]    right_addr;
  logic             accept;

  // Kernel stage
  logic             s1_valid;
  logic             s1_fire;
  logic [PIX_W-1:0] s1_px;
  logic [ROW_W-1:0] s1_row;
  logic [AW-1:0]    s1_col;
  logic             s1_emit;
  logic             s1_interior;
  logic             s1_lastrow;
  logic             s1_done;
  logic [PIX_W-1:0] left_q;
  lsf_taps_t        taps;

  logic [10:0]      five_c;
  logic [9:0]       sum4;
  logic signed [11:0] diff;
  logic [PIX_W-1:0] kern_val;

  lsf_result_t      res_a;
  lsf_result_t      res_b;
  lsf_result_t      oq_data;
  logic             oq_space_two;
  logic             oq_valid;

  // ---------------------------------------------------------------- config
  always_comb begin
    cfg_w_ext = WW'(cfg_data);
    if (cfg_w_ext < MIN_W) begin
      width_clamp = MIN_W;
    end else if (cfg_w_ext > MAX_W) begin
      width_clamp = MAX_W;
    end else begin
      width_clamp = cfg_w_ext;
    end
    height_clamp = (cfg_data < MIN_H) ? MIN_H : cfg_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_eff  <= WW'(WIDTH_RESET);
      height_eff <= ROW_W'(HEIGHT_RESET);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:  width_eff  <= width_clamp;
        REG_FRAME_HEIGHT: height_eff <= height_clamp;
        default: ;
      endcase
    end
  end

  // -------------------------------------------------------------- position
  // Start of frame forces (0,0); a column past a narrowed width wraps to the
  // next row, and a row past a lowered height wraps to row 0.
  always_comb begin
    col_sel    = s_axis_tuser ? '0 : col_q;
    row_sel    = s_axis_tuser ? '0 : row_q;
    col_wrap   = CW'(col_sel) >= CW'(width_eff);
    row_adv    = col_wrap ? ({1'b0, row_sel} + (ROW_W + 1)'(1)) : {1'b0, row_sel};
    cur_row    = (row_adv >= {1'b0, height_eff}) ? '0 : row_adv[ROW_W-1:0];
    cur_col    = col_wrap ? '0 : col_sel;
    col_inc    = {1'b0, cur_col} + (AW + 1)'(1);
    end_of_row = CW'(col_inc) >= CW'(width_eff);
    row_inc    = {1'b0, cur_row} + (ROW_W + 1)'(1);
    next_row   = (row_inc >= {1'b0, height_eff}) ? '0 : row_inc[ROW_W-1:0];
    right_addr = (col_inc == COL_END) ? '0 : col_inc[AW-1:0];
  end

  assign s1_fire       = s1_valid && oq_space_two;
  assign s_axis_tready = !s1_valid || s1_fire;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= end_of_row ? '0 : col_inc[AW-1:0];
      row_q <= end_of_row ? next_row : cur_row;
    end
  end

  // Hold the pixel and its flags while the line store read is in flight.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept || (s1_valid && !s1_fire);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px       <= s_axis_tdata;
      s1_row      <= cur_row;
      s1_col      <= cur_col;
      s1_emit     <= (cur_row != '0);
      s1_interior <= (cur_row >= ROW_W'(2)) && (cur_col != '0) && !end_of_row;
      s1_lastrow  <= (cur_row == (height_eff - ROW_W'(1)));
      s1_done     <= (cur_row == (height_eff - ROW_W'(1))) && end_of_row;
    end
  end

  // Left neighbor is the center of the pixel before.
  always_ff @(posedge clk) begin
    if (rst) begin
      left_q <= '0;
    end else if (s1_fire) begin
      left_q <= taps.center;
    end
  end

  // ------------------------------------------------------------ line store
  // Write back this column: center moves down to two-above, pixel to above.
  lsf_line_store #(
    .DEPTH  (MAX_WIDTH),
    .ADDR_W (AW)
  ) u_line_store (
    .clk           (clk),
    .rd_en         (accept),
    .rd_addr       (cur_col),
    .rd_addr_right (right_addr),
    .wr_en         (s1_fire),
    .wr_addr       (s1_col),
    .wr_above      (s1_px),
    .wr_two_above  (taps.center),
    .taps          (taps)
  );

  // ---------------------------------------------------------------- kernel
  always_comb begin
    five_c = {1'b0, taps.center, 2'b00} + 11'(taps.center);
    sum4   = 10'(taps.up) + 10'(s1_px) + 10'(left_q) + 10'(taps.right);
    diff   = $signed({1'b0, five_c}) - $signed({2'b00, sum4});
    if (diff < 0) begin
      kern_val = '0;
    end else if (diff > 12'sd255) begin
      kern_val = 8'hFF;
    end else begin
      kern_val = diff[PIX_W-1:0];
    end

    res_a.sharpened  = s1_interior ? kern_val : '0;
    res_a.row        = s1_row - ROW_W'(1);
    res_a.col        = COL_W'(s1_col);
    res_a.last       = !s1_lastrow;
    res_a.frame_done = 1'b0;

    // Bottom-border zero for the pixel itself.
    res_b.sharpened  = '0;
    res_b.row        = s1_row;
    res_b.col        = COL_W'(s1_col);
    res_b.last       = 1'b1;
    res_b.frame_done = s1_done;
  end

  // ---------------------------------------------------------- output queue
  lsf_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (s1_fire && s1_emit),
    .push_two  (s1_lastrow),
    .in_a      (res_a),
    .in_b      (res_b),
    .space_two (oq_space_two),
    .out_valid (oq_valid),
    .out_ready (m_axis_tready),
    .out_data  (oq_data)
  );

  assign m_axis_tvalid = oq_valid;
  assign m_axis_tdata  = TDATA_W'({oq_data.col, oq_data.row, oq_data.sharpened});
  assign m_axis_tlast  = oq_data.last;
  assign m_axis_tuser  = oq_data.frame_done;

endmodule

>>> rtl/lsf_checker.sv
// ----------------------------------------------------------------------------
// lsf_checker
// Port-level checks of the sharpen filter output stream, bound to the core.
// ----------------------------------------------------------------------------
module lsf_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [lsf_pkg::TDATA_W-1:0] m_axis_tdata,
  input logic                        m_axis_tlast,
  input logic                        m_axis_tuser
);
  import lsf_pkg::*;

  // End of frame is a bottom-border word, hence the last of its pixel.
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
    else $error("frame_done without tlast");

  a_done_is_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[7:0] == 8'h00))
    else $error("frame_done on nonzero value");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[TDATA_W-1] == 1'b0))
    else $error("tdata pad bit set");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
       && $stable(m_axis_tuser)))
    else $error("output word changed while stalled");

endmodule

bind laplacian_sharpen_filter_core lsf_checker u_lsf_checker (.*);
